// File: design/stroke_target_to_motion_setpoint_core_macros.svh
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef STROKE_TARGET_TO_MOTION_SETPOINT_CORE_MACROS_SVH
`define STROKE_TARGET_TO_MOTION_SETPOINT_CORE_MACROS_SVH

// Same-cycle implication.
`define STMSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/stmsp_pkg.sv
package stmsp_pkg;

	// Position registers are two's complement in this many bits.
	localparam int POS_WIDTH = 32;

	localparam int PCT_W       = 7;
	localparam int SPAN_W      = POS_WIDTH + 1;
	localparam int SPD_MUL_W   = 11;
	localparam int MUL_W       = SPAN_W + SPD_MUL_W;
	localparam int DIVD_W      = ((MUL_W + 1) / 2) * 2;
	localparam int DIVR_W      = 17;
	localparam int DIV_STEPS   = DIVD_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int SPEED_W     = 20;
	localparam int ACCEL_W     = 24;
	localparam int DUR_W       = 32;

	localparam logic [PCT_W-1:0]     PCT_MAX     = PCT_W'(100);
	localparam logic [DIVR_W-1:0]    PCT_DIV     = DIVR_W'(100);
	localparam logic [SPD_MUL_W-1:0] SPEED_SCALE = SPD_MUL_W'(1500);
	localparam logic [DIVR_W-1:0]    DUR_MIN     = DIVR_W'(20);
	localparam logic [DIVR_W-1:0]    DUR_MAX     = DIVR_W'(120000);
	localparam logic [ACCEL_W-1:0]   ACCEL_FLOOR = ACCEL_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHYS_MIN    = 3'd0,
		REG_PHYS_MAX    = 3'd1,
		REG_STROKE_LOW  = 3'd2,
		REG_STROKE_HIGH = 3'd3,
		REG_MAX_SPEED   = 3'd4,
		REG_MAX_ACCEL   = 3'd5,
		REG_START_POS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [POS_WIDTH-1:0] phys_min;
		logic [POS_WIDTH-1:0] phys_max;
		logic [POS_WIDTH-1:0] stroke_low;
		logic [POS_WIDTH-1:0] stroke_high;
		logic [SPEED_W-1:0]   max_speed;
		logic [ACCEL_W-1:0]   max_accel;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

	// When the two are inverted, values below the low limit give the low limit and all others the high limit.
	function automatic logic [POS_WIDTH-1:0] clamp_pos(
		input logic [POS_WIDTH-1:0] x,
		input logic [POS_WIDTH-1:0] lo,
		input logic [POS_WIDTH-1:0] hi
	);
		logic [POS_WIDTH-1:0] r;
		if ($signed(x) < $signed(lo)) begin
			r = lo;
		end else if ($signed(x) > $signed(hi)) begin
			r = hi;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

// File: design/stmsp_cfg.sv
module stmsp_cfg import stmsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_idx,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg,
	output logic                  start_wr
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{phys_min: '0, phys_max: '0, stroke_low: '0, stroke_high: '0,
				max_speed: SPEED_W'(1), max_accel: ACCEL_W'(1)};
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_idx))
				REG_PHYS_MIN:    cfg_q.phys_min    <= wr_data[POS_WIDTH-1:0];
				REG_PHYS_MAX:    cfg_q.phys_max    <= wr_data[POS_WIDTH-1:0];
				REG_STROKE_LOW:  cfg_q.stroke_low  <= wr_data[POS_WIDTH-1:0];
				REG_STROKE_HIGH: cfg_q.stroke_high <= wr_data[POS_WIDTH-1:0];
				REG_MAX_SPEED:   cfg_q.max_speed   <= wr_data[SPEED_W-1:0];
				REG_MAX_ACCEL:   cfg_q.max_accel   <= wr_data[ACCEL_W-1:0];
				default: ;
			endcase
		end
	end

	// The motor position itself lives in the core as the last target.
	assign start_wr = wr_en && (reg_idx_t'(wr_idx) == REG_START_POS);
	assign cfg      = cfg_q;

endmodule

// File: design/stmsp_div.sv
module stmsp_div import stmsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dvr_q;
	logic [DIVD_W-1:0]    quo_q;

	logic [DIVR_W:0] r1, r1s, r2, r2s, dvr_ext;
	logic            ge1, ge2;

	// Two restoring steps per cycle.
	always_comb begin
		dvr_ext = {1'b0, dvr_q};
		r1      = {rem_q, quo_q[DIVD_W-1]};
		ge1     = r1 >= dvr_ext;
		r1s     = ge1 ? (r1 - dvr_ext) : r1;
		r2      = {r1s[DIVR_W-1:0], quo_q[DIVD_W-2]};
		ge2     = r2 >= dvr_ext;
		r2s     = ge2 ? (r2 - dvr_ext) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= r2s[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-3:0], ge1, ge2};
		end
	end

	assign rsp.done     = busy_q && (cnt_q == DIV_CNT_W'(1));
	assign rsp.quotient = quo_q;

endmodule

// File: design/stroke_target_to_motion_setpoint_core.sv
// A command runs through the sequencer states in turn; m_tvalid rises as it leaves FIN.
// Only one command is processed at a time; the shared radix-4 divider runs twice
// per command and takes up most of the time spent on it.
// A finished result waits in the output register while the next command is taken.
// Reset: asynchronous, active low; clears the sequencer, the output valid and the
// registers to their reset values (last target 0, max speed and max accel 1).
module stroke_target_to_motion_setpoint_core import stmsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// s_tdata: stroke_pct[7:0], move_time[39:8], replace[40], zero fill
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// m_tdata: stop_first[0], move_valid[1], target_pos[33:2], speed_hz[53:34],
	//          accel_value[77:54], zero fill
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// One-hot sequencer: clamp limits, map percent (divide by 100), clamp target,
	// take distance, then derive speed (second divide) and finish.
	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_LO   = 12'b0000_0000_0010,
		ST_HI   = 12'b0000_0000_0100,
		ST_SPAN = 12'b0000_0000_1000,
		ST_MUL1 = 12'b0000_0001_0000,
		ST_DIV1 = 12'b0000_0010_0000,
		ST_TGT  = 12'b0000_0100_0000,
		ST_CLP  = 12'b0000_1000_0000,
		ST_DIST = 12'b0001_0000_0000,
		ST_MUL2 = 12'b0010_0000_0000,
		ST_DIV2 = 12'b0100_0000_0000,
		ST_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	cfg_t     cfg;
	logic     start_wr;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Command fields, held for the whole run.
	logic [PCT_W-1:0]     pct_q;
	logic [DUR_W-1:0]     dur_q;
	logic                 rep_q;

	logic [POS_WIDTH-1:0] lo_q;
	logic [POS_WIDTH-1:0] hi_q;
	logic [SPAN_W-1:0]    span_q;
	logic [POS_WIDTH-1:0] tgt_q;
	logic [POS_WIDTH-1:0] last_q;
	logic [SPAN_W-1:0]    dist_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                   in_xfer;
	logic                   fin_go;
	logic [PCT_W-1:0]       in_pct;
	logic [SPAN_W-1:0]      mul_a;
	logic [SPD_MUL_W-1:0]   mul_b;
	logic [MUL_W-1:0]       mul_p;
	logic [DIVR_W-1:0]      dur_clamped;
	logic [SPAN_W-1:0]      tgt_sum;
	logic [SPAN_W-1:0]      tgt_ext;
	logic [SPAN_W-1:0]      last_ext;
	logic                   move;
	logic [SPEED_W-1:0]     spd_lim;
	logic [SPEED_W-1:0]     speed;
	logic [ACCEL_W-1:0]     acc_half;
	logic [ACCEL_W-1:0]     acc_floor;
	logic [ACCEL_W-1:0]     acc_lim;
	logic [ACCEL_W-1:0]     accel;

	stmsp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_idx   (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.start_wr (start_wr)
	);

	stmsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	// Leave FIN only when the output register is free or drains this cycle.
	assign fin_go    = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Saturate the percentage at 100.
	assign in_pct = (s_tdata[7:0] > 8'(PCT_MAX)) ? PCT_MAX : s_tdata[PCT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_LO;
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = ST_SPAN;
			ST_SPAN: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_DIV1;
			ST_DIV1: if (div_rsp.done) state_d = ST_TGT;
			ST_TGT:  state_d = ST_CLP;
			ST_CLP:  state_d = ST_DIST;
			ST_DIST: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV2;
			ST_DIV2: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:  if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Duration clamped to 20..120000 ms; never zero, so always a legal divisor.
	always_comb begin
		if (dur_q < DUR_W'(DUR_MIN)) begin
			dur_clamped = DUR_MIN;
		end else if (dur_q > DUR_W'(DUR_MAX)) begin
			dur_clamped = DUR_MAX;
		end else begin
			dur_clamped = dur_q[DIVR_W-1:0];
		end
	end

	// Shared multiplier feeds the divider: span*pct/100, then 1500*dist/duration.
	always_comb begin
		mul_a = (state_q == ST_MUL1) ? span_q : dist_q;
		mul_b = (state_q == ST_MUL1) ? SPD_MUL_W'(pct_q) : SPEED_SCALE;
		mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
		div_req.start    = (state_q == ST_MUL1) || (state_q == ST_MUL2);
		div_req.dividend = DIVD_W'(mul_p);
		div_req.divisor  = (state_q == ST_MUL1) ? PCT_DIV : dur_clamped;
	end

	// Quotient is at most the span, so the low SPAN_W bits hold it whole.
	assign tgt_sum  = {lo_q[POS_WIDTH-1], lo_q} + div_rsp.quotient[SPAN_W-1:0];
	assign tgt_ext  = {tgt_q[POS_WIDTH-1], tgt_q};
	assign last_ext = {last_q[POS_WIDTH-1], last_q};

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pct_q <= in_pct;
			dur_q <= s_tdata[39:8];
			rep_q <= s_tdata[40];
		end
		if (state_q == ST_LO) begin
			lo_q <= clamp_pos(cfg.stroke_low, cfg.phys_min, cfg.phys_max);
		end
		if (state_q == ST_HI) begin
			hi_q <= clamp_pos(cfg.stroke_high, cfg.phys_min, cfg.phys_max);
		end
		// An inverted stroke collapses onto its low end.
		if (state_q == ST_SPAN) begin
			span_q <= ($signed(hi_q) > $signed(lo_q)) ?
				({hi_q[POS_WIDTH-1], hi_q} - {lo_q[POS_WIDTH-1], lo_q}) : '0;
		end
		if (state_q == ST_TGT) begin
			tgt_q <= tgt_sum[POS_WIDTH-1:0];
		end else if (state_q == ST_CLP) begin
			tgt_q <= clamp_pos(tgt_q, cfg.phys_min, cfg.phys_max);
		end
		if (state_q == ST_DIST) begin
			dist_q <= ($signed(tgt_q) >= $signed(last_q)) ?
				(tgt_ext - last_ext) : (last_ext - tgt_ext);
		end
	end

	// Last target: loaded by a start position write, updated once per command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (start_wr) begin
			last_q <= cfg_data[POS_WIDTH-1:0];
		end else if (state_q == ST_DIST) begin
			last_q <= tgt_q;
		end
	end

	// Speed and acceleration: zero with no move, else saturated into 1..max (1 if max is 0).
	always_comb begin
		move    = (dist_q != '0);
		spd_lim = (div_rsp.quotient > DIVD_W'(cfg.max_speed)) ?
			cfg.max_speed : div_rsp.quotient[SPEED_W-1:0];
		acc_half  = {1'b0, cfg.max_accel[ACCEL_W-1:1]};
		acc_floor = (acc_half < ACCEL_FLOOR) ? ACCEL_FLOOR : acc_half;
		acc_lim   = (acc_floor > cfg.max_accel) ? cfg.max_accel : acc_floor;
		if (!move) begin
			speed = '0;
			accel = '0;
		end else if (dur_q == '0) begin
			speed = (cfg.max_speed == '0) ? SPEED_W'(1) : cfg.max_speed;
			accel = (cfg.max_accel == '0) ? ACCEL_W'(1) : cfg.max_accel;
		end else begin
			speed = (spd_lim == '0) ? SPEED_W'(1) : spd_lim;
			accel = (acc_lim == '0) ? ACCEL_W'(1) : acc_lim;
		end
	end

	// Output register: hold until the transfer, advance on fin_go.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tdata_q <= {2'b00, accel, speed, 32'($signed(tgt_q)), move, rep_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: design/stmsp_chk.sv
`include "stroke_target_to_motion_setpoint_core_macros.svh"

module stmsp_chk import stmsp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result holds.
	`STMSP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// One command at a time: input closes right after a transfer.
	`STMSP_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input still open after a transfer")

	// No move means zero speed and acceleration.
	`STMSP_ASSERT_NOW(a_no_move_zero, m_tvalid && !m_tdata[1], m_tdata[77:34] == '0, "rate given without a move")

	// A move always carries nonzero speed and acceleration.
	`STMSP_ASSERT_NOW(a_move_nonzero, m_tvalid && m_tdata[1], (m_tdata[53:34] != '0) && (m_tdata[77:54] != '0), "move with zero rate")

endmodule

bind stroke_target_to_motion_setpoint_core stmsp_chk u_stmsp_chk (.*);
